// ===== rtl/mtu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-turn encoder unwrap block: field widths, register
// indexes and reset values. No dependencies.
package mtu_pkg;

    localparam int POS_W        = 16;   // raw_position and step_delta
    localparam int TOTAL_W      = 32;   // relative, absolute and near-turn totals
    localparam int SCALED_W     = 48;   // scaled_turns
    localparam int MUL_CHUNK_W  = 32;   // magnitude slice fed to the multiplier per cycle

    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = POS_W + 3 * TOTAL_W + SCALED_W;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_COUNTS_PER_REV = 1'b0;
    localparam cfg_idx_t REG_GEAR_RATIO     = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CPR_RESET  = 16'd8192;
    localparam logic [CFG_DATA_W-1:0] GEAR_RESET = 16'd1;

endpackage

// ===== rtl/multiturn_encoder_unwrap_top.sv =====
`timescale 1ns / 1ps
// Each input transaction passes through the diff, fold, accumulate, near-turn, magnitude,
// multiply and radix-4 divide steps before the result is loaded into the output register;
// the next input transaction is taken only once the sequencer is back in idle.
// Only one item is in the sequencer at a time; a finished result waits in the output register.
// Synchronous active-low reset clears the accumulators, the first-sample flag and
// the handshakes, and restores counts_per_rev = 8192 and gear_ratio = 1.
// Depends on mtu_pkg.
module multiturn_encoder_unwrap_top #(
    parameter int ACC_WIDTH = 32,
    parameter int FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: raw_position [15:0]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mtu_pkg::S_TDATA_W-1:0]    s_tdata,
    // m_tdata: step_delta [15:0], relative_total [47:16], absolute_total [79:48],
    //          near_turn_total [111:80], scaled_turns [159:112]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mtu_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mtu_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mtu_pkg::*;

    localparam int KW        = CFG_DATA_W + FRAC_BITS;          // gear_ratio << FRAC_BITS
    localparam int NCH       = (ACC_WIDTH + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int MW        = NCH * MUL_CHUNK_W;
    localparam int MULW      = MUL_CHUNK_W + KW;
    localparam int PW        = ACC_WIDTH + KW;
    localparam int DIV_STEPS = (PW + 1) / 2;
    localparam int PE        = 2 * DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int FW        = POS_W + 2;                       // fold arithmetic width

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_FOLD, ST_ACC, ST_NEAR, ST_MAG, ST_MUL, ST_DIV, ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [CFG_DATA_W-1:0]           counts_per_rev_reg;
    logic [CFG_DATA_W-1:0]           gear_ratio_reg;
    logic [POS_W-1:0]                raw_reg;
    logic [POS_W-1:0]                prev_position_reg;
    logic                            seen_first_reg;
    logic signed [POS_W-1:0]         step_reg;
    logic signed [ACC_WIDTH-1:0]     relative_acc_reg;
    logic signed [ACC_WIDTH-1:0]     absolute_acc_reg;
    logic signed [ACC_WIDTH-1:0]     near_turn_acc_reg;
    logic                            neg_reg;
    logic [MW-1:0]                   mag_reg;
    logic [MULW-1:0]                 mul_reg;
    logic [PE-1:0]                   prod_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [POS_W-1:0]                rem_reg;
    logic [SCALED_W-1:0]             quo_reg;
    logic                            m_tvalid_reg;
    logic [M_TDATA_W-1:0]            m_tdata_reg;

    // Step forming and folding.
    logic [POS_W-1:0]                prev_eff;
    logic signed [POS_W-1:0]         diff_next;
    logic signed [FW-1:0]            half_s;
    logic signed [FW-1:0]            cpr_s;
    logic signed [FW-1:0]            e0_s;
    logic signed [POS_W-1:0]         fold1;
    logic signed [FW-1:0]            e1_s;
    logic signed [POS_W-1:0]         step_next;

    always_comb begin
        prev_eff  = seen_first_reg ? prev_position_reg : raw_reg;
        diff_next = signed'(raw_reg - prev_eff);
        half_s    = signed'({2'b00, 1'b0, counts_per_rev_reg[CFG_DATA_W-1:1]});
        cpr_s     = signed'({2'b00, counts_per_rev_reg});
        e0_s      = FW'(step_reg);
        fold1     = (e0_s > half_s) ? POS_W'(e0_s - cpr_s) : step_reg;
        e1_s      = FW'(fold1);
        step_next = (e1_s < -half_s) ? POS_W'(e1_s + cpr_s) : fold1;
    end

    // Accumulator update and near-turn fold.
    logic signed [ACC_WIDTH-1:0]     step_ext;
    logic signed [ACC_WIDTH-1:0]     cpr_acc;
    logic signed [ACC_WIDTH-1:0]     near_next;
    logic [ACC_WIDTH-1:0]            rel_u;
    logic [ACC_WIDTH-1:0]            mag_next;

    always_comb begin
        step_ext = ACC_WIDTH'(step_reg);
        cpr_acc  = signed'(ACC_WIDTH'(counts_per_rev_reg));
        if (near_turn_acc_reg > cpr_acc) begin
            near_next = near_turn_acc_reg - cpr_acc;
        end else if (near_turn_acc_reg < -cpr_acc) begin
            near_next = near_turn_acc_reg + cpr_acc;
        end else begin
            near_next = near_turn_acc_reg;
        end
        rel_u    = relative_acc_reg;
        mag_next = rel_u[ACC_WIDTH-1] ? (~rel_u + 1'b1) : rel_u;
    end

    // Multiplier operands: one 32-bit magnitude slice times the shifted gear ratio.
    logic [KW-1:0]                   mult_k;
    logic [MUL_CHUNK_W-1:0]          chunk;

    assign mult_k = KW'(gear_ratio_reg) << FRAC_BITS;
    assign chunk  = mag_reg[MW-1 -: MUL_CHUNK_W];

    // Two restoring division steps per cycle on the product held in prod_reg.
    logic [POS_W:0]                  div_t1;
    logic                            div_ge1;
    logic [POS_W-1:0]                div_r1;
    logic [POS_W:0]                  div_t2;
    logic                            div_ge2;
    logic [POS_W-1:0]                div_r2;

    always_comb begin
        div_t1  = {rem_reg, prod_reg[PE-1]};
        div_ge1 = div_t1 >= {1'b0, counts_per_rev_reg};
        div_r1  = div_ge1 ? POS_W'(div_t1 - {1'b0, counts_per_rev_reg}) : POS_W'(div_t1);
        div_t2  = {div_r1, prod_reg[PE-2]};
        div_ge2 = div_t2 >= {1'b0, counts_per_rev_reg};
        div_r2  = div_ge2 ? POS_W'(div_t2 - {1'b0, counts_per_rev_reg}) : POS_W'(div_t2);
    end

    logic [SCALED_W-1:0]             scaled;
    logic [M_TDATA_W-1:0]            result;

    always_comb begin
        if (counts_per_rev_reg == '0) begin
            scaled = '0;
        end else begin
            scaled = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
        end
        result = {scaled, TOTAL_W'(near_turn_acc_reg), TOTAL_W'(absolute_acc_reg),
                  TOTAL_W'(relative_acc_reg), step_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            counts_per_rev_reg <= CPR_RESET;
            gear_ratio_reg     <= GEAR_RESET;
            prev_position_reg  <= '0;
            seen_first_reg     <= 1'b0;
            relative_acc_reg   <= '0;
            absolute_acc_reg   <= '0;
            near_turn_acc_reg  <= '0;
            cnt_reg            <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_COUNTS_PER_REV: counts_per_rev_reg <= cfg_data;
                    REG_GEAR_RATIO:     gear_ratio_reg     <= cfg_data;
                    default: ;
                endcase
            end

            // In the done step the output register is handled there instead.
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        raw_reg   <= s_tdata[POS_W-1:0];
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    // The first sample seeds the absolute count and gives a zero step.
                    if (!seen_first_reg) begin
                        absolute_acc_reg <= absolute_acc_reg + signed'(ACC_WIDTH'(raw_reg));
                    end
                    seen_first_reg    <= 1'b1;
                    prev_position_reg <= raw_reg;
                    step_reg          <= diff_next;
                    state_reg         <= ST_FOLD;
                end
                ST_FOLD: begin
                    step_reg  <= step_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    relative_acc_reg  <= relative_acc_reg + step_ext;
                    absolute_acc_reg  <= absolute_acc_reg + step_ext;
                    near_turn_acc_reg <= near_turn_acc_reg + step_ext;
                    state_reg         <= ST_NEAR;
                end
                ST_NEAR: begin
                    near_turn_acc_reg <= near_next;
                    state_reg         <= ST_MAG;
                end
                ST_MAG: begin
                    neg_reg   <= rel_u[ACC_WIDTH-1];
                    mag_reg   <= MW'(mag_next);
                    prod_reg  <= '0;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // Slices go in from the top; each partial product is registered
                    // before it is folded into the running product.
                    if (cnt_reg < CNT_W'(NCH)) begin
                        mul_reg <= chunk * mult_k;
                        mag_reg <= mag_reg << MUL_CHUNK_W;
                    end
                    if (cnt_reg != '0) begin
                        prod_reg <= (prod_reg << MUL_CHUNK_W) + PE'(mul_reg);
                    end
                    if (cnt_reg == CNT_W'(NCH)) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= div_r2;
                    quo_reg  <= {quo_reg[SCALED_W-3:0], div_ge1, div_ge2};
                    prod_reg <= prod_reg << 2;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= result;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // An accepted transaction blocks the input until the sequencer returns to idle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // A result only appears from the final sequencer step.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done step");

    // Every accepted sample has marked the first sample as seen once its diff step is done.
    a_first_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 seen_first_reg)
        else $error("first-sample flag not set");

    // A zero revolution count forces the scaled output to zero.
    a_zero_cpr: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) && counts_per_rev_reg == '0
        |-> m_tdata_reg[M_TDATA_W-1 -: SCALED_W] == '0)
        else $error("scaled output nonzero with zero counts per revolution");

endmodule

// ===== sim/tb_multiturn_encoder_unwrap_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multiturn_encoder_unwrap_top: streams encoder readings in,
// predicts the step, the three totals and the scaled turns per reading, and compares.
// Depends on mtu_pkg and the RTL of the block.
module tb_multiturn_encoder_unwrap_top;
    import mtu_pkg::*;

    localparam int ACC_WIDTH  = 32;
    localparam int FRAC_BITS  = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    // Packed so that step_delta lands in the low bits, as on m_tdata.
    typedef struct packed {
        logic signed [SCALED_W-1:0] scaled_turns;
        logic signed [TOTAL_W-1:0]  near_turn_total;
        logic signed [TOTAL_W-1:0]  absolute_total;
        logic signed [TOTAL_W-1:0]  relative_total;
        logic signed [POS_W-1:0]    step_delta;
    } turn_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state and settings.
    logic [15:0]        cpr_setting = CPR_RESET;
    logic [15:0]        gear_setting = GEAR_RESET;
    logic [15:0]        prev_position = '0;
    logic               seen_first = 1'b0;
    logic signed [31:0] relative_acc = '0;
    logic signed [31:0] absolute_acc = '0;
    logic signed [31:0] near_turn_acc = '0;

    turn_result_t turn_results_q[$];
    logic [15:0]  prior_reading = '0;
    logic         steady_flow = 1'b0;
    int           error_count = 0;
    int           stall_cycles = 0;

    multiturn_encoder_unwrap_top #(
        .ACC_WIDTH(ACC_WIDTH),
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Unwraps one reading and returns what the block should report for it.
    function automatic turn_result_t predict_unwrap(input logic [15:0] raw);
        turn_result_t res;
        int cpr;
        int half;
        int step;
        logic signed [15:0] step16;
        longint product;
        longint quotient;
        cpr = int'(cpr_setting);
        half = cpr / 2;
        if (!seen_first) begin
            prev_position = raw;
            absolute_acc = absolute_acc + {16'b0, raw};
            seen_first = 1'b1;
        end
        step16 = raw - prev_position;
        step = step16;
        prev_position = raw;
        if (step > half) begin
            step16 = 16'(step - cpr);
            step = step16;
        end
        if (step < -half) begin
            step16 = 16'(step + cpr);
            step = step16;
        end
        relative_acc = relative_acc + step;
        absolute_acc = absolute_acc + step;
        near_turn_acc = near_turn_acc + step;
        if (near_turn_acc > cpr)
            near_turn_acc = near_turn_acc - cpr;
        else if (near_turn_acc < -cpr)
            near_turn_acc = near_turn_acc + cpr;
        if (cpr == 0) begin
            quotient = 0;
        end else begin
            product = longint'(relative_acc) * (longint'(gear_setting) << FRAC_BITS);
            quotient = product / longint'(cpr);
        end
        res.step_delta = step16;
        res.relative_total = relative_acc;
        res.absolute_total = absolute_acc;
        res.near_turn_total = near_turn_acc;
        res.scaled_turns = quotient[47:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 27);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    // Result checker: every result transaction is matched against the oldest prediction.
    always @(posedge aclk) begin
        turn_result_t got;
        turn_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (turn_results_q.size() == 0) begin
                $error("unexpected result transaction: %h", m_tdata);
                error_count++;
            end else begin
                want = turn_results_q.pop_front();
                if (got.step_delta !== want.step_delta) begin
                    $error("step_delta: expected %0d, actual %0d",
                           want.step_delta, got.step_delta);
                    error_count++;
                end
                if (got.relative_total !== want.relative_total) begin
                    $error("relative_total: expected %0d, actual %0d",
                           want.relative_total, got.relative_total);
                    error_count++;
                end
                if (got.absolute_total !== want.absolute_total) begin
                    $error("absolute_total: expected %0d, actual %0d",
                           want.absolute_total, got.absolute_total);
                    error_count++;
                end
                if (got.near_turn_total !== want.near_turn_total) begin
                    $error("near_turn_total: expected %0d, actual %0d",
                           want.near_turn_total, got.near_turn_total);
                    error_count++;
                end
                if (got.scaled_turns !== want.scaled_turns) begin
                    $error("scaled_turns: expected %0d, actual %0d",
                           want.scaled_turns, got.scaled_turns);
                    error_count++;
                end
            end
        end
    end

    // Offers one reading and returns at the edge where it is taken. tvalid stays high
    // afterwards so that back-to-back readings need no second assignment in one step.
    task automatic send_reading(input logic [15:0] pos);
        while (!steady_flow && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        turn_results_q.push_back(predict_unwrap(pos));
        prior_reading = pos;
    endtask

    // Mostly plausible motion below one revolution, the rest any 16-bit reading.
    task automatic send_random_reading();
        int cpr;
        int delta;
        logic [15:0] pos;
        cpr = int'(cpr_setting);
        if (cpr > 0 && $urandom_range(99) < 80) begin
            delta = int'($urandom_range(cpr)) - cpr / 2;
            pos = 16'(((int'(prior_reading) + delta) % cpr + cpr) % cpr);
        end else begin
            pos = 16'($urandom);
        end
        send_reading(pos);
    endtask

    // Stops the input and waits until the block has returned everything it owes.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (turn_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [15:0] cpr, input logic [15:0] gear);
        cfg_valid <= 1'b1;
        cfg_index <= REG_COUNTS_PER_REV;
        cfg_data <= cpr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cpr_setting = cpr;
        cfg_index <= REG_GEAR_RATIO;
        cfg_data <= gear;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        gear_setting = gear;
        cfg_valid <= 1'b0;
    endtask

    // First sample right after reset, then field extremes and the half-turn boundaries.
    task automatic test_first_sample_and_extremes();
        logic [15:0] readings[11] = '{16'd100, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF,
                                      16'd0, 16'd8191, 16'd0, 16'd4096, 16'd8192, 16'd0};
        foreach (readings[i]) send_reading(readings[i]);
    endtask

    // Steady rotation up and then down, so the near-turn total folds both ways.
    task automatic test_near_turn_fold();
        logic [15:0] pos;
        pos = prior_reading;
        repeat (4) begin
            pos = pos + 16'd4000;
            send_reading(pos);
        end
        repeat (8) begin
            pos = pos - 16'd4000;
            send_reading(pos);
        end
    endtask

    // Extreme settings, including the degenerate zero and one counts per revolution.
    task automatic test_config_extremes();
        logic [15:0] cpr_list[7]  = '{16'd2, 16'hFFFF, 16'd0, 16'd1, 16'd3, 16'd360, 16'd8192};
        logic [15:0] gear_list[7] = '{16'hFFFF, 16'd1, 16'd0, 16'd300, 16'hFFFF, 16'd7,
                                      16'd1};
        foreach (cpr_list[i]) begin
            drain_results();
            write_config(cpr_list[i], gear_list[i]);
            repeat (6) send_random_reading();
        end
    endtask

    // With two counts per revolution, readings far out of range make large steps, which
    // drive the scaled turns past the positive range of the signed 48-bit field.
    task automatic test_scaled_wrap();
        logic [15:0] pos;
        drain_results();
        write_config(16'd2, 16'hFFFF);
        pos = prior_reading;
        repeat (560) begin
            pos = pos + 16'd32767;
            send_reading(pos);
        end
    endtask

    task automatic test_random_motion();
        logic [15:0] common_cpr[5] = '{16'd360, 16'd1024, 16'd4096, 16'd8192, 16'd16384};
        logic [15:0] cpr;
        logic [15:0] gear;
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            if ($urandom_range(1) == 1)
                cpr = common_cpr[$urandom_range(4)];
            else
                cpr = 16'($urandom_range(65535, 2));
            gear = ($urandom_range(3) == 0) ? 16'd1 : 16'($urandom_range(65535, 1));
            write_config(cpr, gear);
            // The first phase runs without any idle cycles on either side.
            steady_flow = (phase == 0);
            repeat (50) send_random_reading();
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_first_sample_and_extremes();
        test_near_turn_fold();
        test_config_extremes();
        test_scaled_wrap();
        test_random_motion();
        drain_results();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mtu_pkg.sv
rtl/multiturn_encoder_unwrap_top.sv
sim/tb_multiturn_encoder_unwrap_top.sv
